// ===== rtl/cwc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and constants for the ack-driven congestion window control.
// ----------------------------------------------------------------------------
package cwc_pkg;

    localparam int WORD_W     = 32;
    localparam int SEG_W      = 16;
    localparam int DIVIDEND_W = WORD_W + SEG_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int ADDR_W     = 5;
    localparam int NUM_REGS   = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_LIMIT     = 3'd0;
    localparam logic [2:0] REG_SEGMENT   = 3'd1;
    localparam logic [2:0] REG_INIT_WIN  = 3'd2;
    localparam logic [2:0] REG_INIT_THR  = 3'd3;
    localparam logic [2:0] REG_INIT_BASE = 3'd4;

    localparam logic [WORD_W-1:0] RST_LIMIT     = 32'd65535;
    localparam logic [SEG_W-1:0]  RST_SEGMENT   = 16'd1460;
    localparam logic [WORD_W-1:0] RST_INIT_WIN  = 32'd1460;
    localparam logic [WORD_W-1:0] RST_INIT_THR  = 32'd65535;
    localparam logic [WORD_W-1:0] RST_INIT_BASE = 32'd0;

    localparam logic [1:0] DUP_TRIGGER = 2'd3;

    typedef enum logic [1:0] {
        MODE_SLOW  = 2'd0,
        MODE_AVOID = 2'd1,
        MODE_FAST  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    // live settings seen by the window logic
    typedef struct packed {
        logic [WORD_W-1:0] limit;
        logic [SEG_W-1:0]  segment;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/cwc_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_regs
// APB register file: window limit, segment size and the initial values.
// ----------------------------------------------------------------------------
module cwc_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cwc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output cwc_pkg::t_cfg                   o_cfg
);
    import cwc_pkg::*;

    logic [WORD_W-1:0] r_limit;
    logic [SEG_W-1:0]  r_segment;
    logic [WORD_W-1:0] r_init_win;
    logic [WORD_W-1:0] r_init_thr;
    logic [WORD_W-1:0] r_init_base;
    logic [2:0]        w_index;
    logic              w_write;

    assign w_index = paddr[ADDR_W-1:2];
    assign w_write = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= RST_LIMIT;
            r_segment   <= RST_SEGMENT;
            r_init_win  <= RST_INIT_WIN;
            r_init_thr  <= RST_INIT_THR;
            r_init_base <= RST_INIT_BASE;
        end else if (w_write) begin
            unique case (w_index)
                REG_LIMIT:     r_limit     <= pwdata;
                REG_SEGMENT:   r_segment   <= pwdata[SEG_W-1:0];
                REG_INIT_WIN:  r_init_win  <= pwdata;
                REG_INIT_THR:  r_init_thr  <= pwdata;
                REG_INIT_BASE: r_init_base <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_LIMIT:     prdata = r_limit;
            REG_SEGMENT:   prdata = {{(32-SEG_W){1'b0}}, r_segment};
            REG_INIT_WIN:  prdata = r_init_win;
            REG_INIT_THR:  prdata = r_init_thr;
            REG_INIT_BASE: prdata = r_init_base;
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.limit   = r_limit;
    assign o_cfg.segment = r_segment;

endmodule
`default_nettype wire

// ===== rtl/cwc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_div
// Restoring radix-2 divider, one quotient bit per cycle, 48 by 32 bits.
// ----------------------------------------------------------------------------
module cwc_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [cwc_pkg::DIVIDEND_W-1:0] i_dividend,
    input  wire logic [cwc_pkg::WORD_W-1:0]     i_divisor,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [cwc_pkg::DIVIDEND_W-1:0]      o_quotient
);
    import cwc_pkg::*;

    logic [WORD_W-1:0]     r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [WORD_W:0]       w_trial;
    logic [WORD_W:0]       w_diff;
    logic                  w_fit;

    // shift in the next dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_fit   = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[WORD_W-1:0] : w_trial[WORD_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");
`endif

endmodule
`default_nettype wire

// ===== rtl/ack_congestion_window_control.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ack_congestion_window_control
// Reno-style byte congestion window, updated once per cumulative ack word.
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// in        sink       i_in_valid / o_in_ready     i_ack_number
// out       source     o_out_valid / i_out_ready   o_window, o_threshold, o_base,
//                                                  o_mode, o_retransmit
// cfg       APB slave  psel, penable, pwrite       paddr, pwdata, prdata
//
// For duplicate and slow-start acks the accept moves the state to done, and o_out_valid
// rises once the output register is free and loaded from there. Avoidance and fast-recovery
// exit go through a divider start, 48 steps of the serial divider that forms
// acked*segment/window, an add-and-cap and the output load.
// One ack word is in work at a time; the finished result sits in an output
// register, so a new word is taken while the previous result is stalled.
// Synchronous reset loads window 1460, threshold 65535, base 0, slow start.
// ----------------------------------------------------------------------------
module ack_congestion_window_control (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [31:0]                i_ack_number,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [31:0]                     o_window,
    output logic [31:0]                     o_threshold,
    output logic [31:0]                     o_base,
    output logic [1:0]                      o_mode,
    output logic                            o_retransmit,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cwc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cwc_pkg::*;

    t_cfg w_cfg;

    t_state            r_state, n_state;
    logic [WORD_W-1:0] r_cwnd, n_cwnd;
    logic [WORD_W-1:0] r_ssthresh, n_ssthresh;
    logic [WORD_W-1:0] r_base, n_base;
    t_mode             r_mode, n_mode;
    logic [1:0]        r_dup, n_dup;
    logic              r_resend, n_resend;
    logic [WORD_W-1:0] r_acked, n_acked;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_window;
    logic [WORD_W-1:0] r_out_threshold;
    logic [WORD_W-1:0] r_out_base;
    t_mode             r_out_mode;
    logic              r_out_resend;

    logic                  w_accept;
    logic                  w_load_out;
    logic                  w_div_start;
    logic                  w_div_busy;
    logic                  w_div_done;
    logic [DIVIDEND_W-1:0] w_product;
    logic [DIVIDEND_W-1:0] w_quotient;
    logic [WORD_W-1:0]     w_divisor;
    logic [WORD_W:0]       w_exp_sum;
    logic [DIVIDEND_W:0]   w_lin_sum;
    logic [WORD_W-1:0]     w_exp_win;
    logic [1:0]            w_dup_inc;

    cwc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_product = DIVIDEND_W'(r_acked) * DIVIDEND_W'(w_cfg.segment);
    assign w_divisor = (r_cwnd == '0) ? WORD_W'(1) : r_cwnd;

    cwc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_product),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign w_exp_sum = {1'b0, r_cwnd} + {1'b0, i_ack_number - r_base};
    assign w_exp_win = (w_exp_sum > {1'b0, w_cfg.limit}) ? w_cfg.limit
                                                         : w_exp_sum[WORD_W-1:0];
    assign w_lin_sum = {{(SEG_W+1){1'b0}}, r_cwnd} + {1'b0, w_quotient};
    assign w_dup_inc = r_dup + 2'd1;

    always_comb begin
        n_state     = r_state;
        n_cwnd      = r_cwnd;
        n_ssthresh  = r_ssthresh;
        n_base      = r_base;
        n_mode      = r_mode;
        n_dup       = r_dup;
        n_resend    = r_resend;
        n_acked     = r_acked;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_resend = 1'b0;
                    n_state  = S_DONE;
                    if (i_ack_number == r_base) begin
                        // duplicate: counted outside fast recovery
                        if (r_mode != MODE_FAST) begin
                            if (w_dup_inc == DUP_TRIGGER) begin
                                n_dup      = '0;
                                n_ssthresh = r_cwnd >> 1;
                                n_cwnd     = r_cwnd >> 1;
                                n_mode     = MODE_FAST;
                                n_resend   = 1'b1;
                            end else begin
                                n_dup = w_dup_inc;
                            end
                        end
                    end else begin
                        n_dup  = '0;
                        n_base = i_ack_number;
                        if (r_mode == MODE_SLOW) begin
                            n_cwnd = w_exp_win;
                            if (w_exp_win >= r_ssthresh) begin
                                n_mode = MODE_AVOID;
                            end
                        end else begin
                            n_mode  = MODE_AVOID;
                            n_acked = i_ack_number - r_base;
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_cwnd  = (w_lin_sum > {{(SEG_W+1){1'b0}}, w_cfg.limit})
                              ? w_cfg.limit : w_lin_sum[WORD_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cwnd     <= RST_INIT_WIN;
            r_ssthresh <= RST_INIT_THR;
            r_base     <= RST_INIT_BASE;
            r_mode     <= MODE_SLOW;
            r_dup      <= '0;
            r_resend   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cwnd     <= n_cwnd;
            r_ssthresh <= n_ssthresh;
            r_base     <= n_base;
            r_mode     <= n_mode;
            r_dup      <= n_dup;
            r_resend   <= n_resend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acked <= n_acked;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_window    <= r_cwnd;
            r_out_threshold <= r_ssthresh;
            r_out_base      <= r_base;
            r_out_mode      <= r_mode;
            r_out_resend    <= r_resend;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window     = r_out_window;
    assign o_threshold  = r_out_threshold;
    assign o_base       = r_out_base;
    assign o_mode       = r_out_mode;
    assign o_retransmit = r_out_resend;

`ifndef NO_ASSERTIONS
    a_resend_in_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_retransmit) |-> (o_mode == MODE_FAST))
        else $error("retransmit reported outside fast recovery");
    a_resend_halved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_retransmit) |-> (o_window == o_threshold))
        else $error("retransmit result with window not at threshold");
    a_div_in_avoid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_mode == MODE_AVOID && w_div_busy)
            || (r_state == S_DIV && w_div_done))
        else $error("division running outside avoidance or divider idle");
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_state == S_IDLE && o_out_valid))
        else $error("result load did not return to idle");
`endif

endmodule
`default_nettype wire
